### src/ucp_pkg.sv
`default_nettype none
// -----------------------------------------------------------------------------
// ucp_pkg
// Shared widths, codes and controller/datapath signal groups of the upload
// chunk planner.
// -----------------------------------------------------------------------------
package ucp_pkg;

	localparam int MAX_COMMANDS = 64;

	localparam int IMG_W   = 13;
	localparam int LAYER_W = 7;
	localparam int BPP_W   = 5;
	localparam int LIMIT_W = 29;
	localparam int ROWB_W  = IMG_W + BPP_W;     // bytes in one row
	localparam int LAYB_W  = ROWB_W + IMG_W;    // bytes in one layer
	localparam int DIV_W   = LAYB_W;            // covers LIMIT_W as well
	localparam int CMDS_W  = IMG_W + LAYER_W;   // bands * layers

	localparam int FLAYER_W = 6;
	localparam int FROW_W   = 12;

	typedef logic [IMG_W-1:0]   img_t;
	typedef logic [LAYER_W-1:0] layer_t;
	typedef logic [BPP_W-1:0]   bpp_t;
	typedef logic [LIMIT_W-1:0] limit_t;
	typedef logic [ROWB_W-1:0]  rowb_t;
	typedef logic [LAYB_W-1:0]  layb_t;
	typedef logic [DIV_W-1:0]   div_t;
	typedef logic [CMDS_W-1:0]  cmds_t;

	localparam limit_t CHUNK_RESET = limit_t'(16 * 1024 * 1024);

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_BAD_ARGS  = 2'd1,
		ST_ROW_BIG   = 2'd2,
		ST_TOO_MANY  = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		DIV_LAYER = 2'd0,   // limit / layer bytes
		DIV_ROW   = 2'd1,   // limit / row bytes
		DIV_BANDS = 2'd2    // ceil(height / rows per band)
	} div_sel_t;

	typedef struct packed {
		img_t   image_width;
		img_t   image_height;
		layer_t layer_total;
		bpp_t   bytes_per_texel;
	} req_t;

	typedef struct packed {
		logic [FLAYER_W-1:0] first_layer;
		logic [LAYER_W-1:0]  layer_span;
		logic [FROW_W-1:0]   first_row;
		logic [IMG_W-1:0]    row_span;
		logic                last;
		status_t             status;
	} chunk_t;

	// controller -> datapath
	typedef struct packed {
		logic     load;
		logic     mul_row;
		logic     mul_layer;
		logic     div_start;
		div_sel_t div_sel;
		logic     take_quo;
		logic     set_n_all;
		logic     mul_ncmd;
		logic     emit_init;
		logic     emit;
		logic     emit_err;
		status_t  err_code;
		logic     row_mode;
	} ctl_t;

	// datapath -> controller
	typedef struct packed {
		logic bad_args;
		logic fits;
		logic layer_zero;
		logic row_big;
		logic div_done;
		logic too_many;
		logic last_cmd;
		logic out_free;
	} stat_t;

endpackage
`default_nettype wire

### src/ucp_req_if.sv
`default_nettype none
// -----------------------------------------------------------------------------
// ucp_req_if
// Request channel: one image transfer to be planned.
// -----------------------------------------------------------------------------
interface ucp_req_if;
	logic                       valid;
	logic                       ready;
	logic [ucp_pkg::IMG_W-1:0]   image_width;
	logic [ucp_pkg::IMG_W-1:0]   image_height;
	logic [ucp_pkg::LAYER_W-1:0] layer_total;
	logic [ucp_pkg::BPP_W-1:0]   bytes_per_texel;

	modport source (output valid, image_width, image_height, layer_total,
		bytes_per_texel, input ready);
	modport sink (input valid, image_width, image_height, layer_total,
		bytes_per_texel, output ready);
endinterface
`default_nettype wire

### src/ucp_chunk_if.sv
`default_nettype none
// -----------------------------------------------------------------------------
// ucp_chunk_if
// Result channel: one chunk command or one error result.
// -----------------------------------------------------------------------------
interface ucp_chunk_if;
	logic                         valid;
	logic                         ready;
	logic [ucp_pkg::FLAYER_W-1:0] first_layer;
	logic [ucp_pkg::LAYER_W-1:0]  layer_span;
	logic [ucp_pkg::FROW_W-1:0]   first_row;
	logic [ucp_pkg::IMG_W-1:0]    row_span;
	logic                         last;
	logic [1:0]                   status;

	modport source (output valid, first_layer, layer_span, first_row, row_span,
		last, status, input ready);
	modport sink (input valid, first_layer, layer_span, first_row, row_span,
		last, status, output ready);
endinterface
`default_nettype wire

### src/ucp_cfg_if.sv
`default_nettype none
// -----------------------------------------------------------------------------
// ucp_cfg_if
// Configuration write channel for the chunk byte limit.
// -----------------------------------------------------------------------------
interface ucp_cfg_if;
	logic                        valid;
	logic                        ready;
	logic [ucp_pkg::LIMIT_W-1:0] max_chunk_bytes;

	modport source (output valid, max_chunk_bytes, input ready);
	modport sink (input valid, max_chunk_bytes, output ready);
endinterface
`default_nettype wire

### src/upload_chunk_planner_unit.sv
`default_nettype none
// Sequence: argument and row-size errors follow the row and layer byte products
//   and the check; grouped layers give their first command after one divide (none
//   if a layer has zero bytes), row bands after two divides; a plan-size error likewise.
// Throughput: one command per cycle while the result side takes them; the next
//   request is taken once the final command sits in the output register.
// Reset: limit returns to 16 MiB, sequencer idle, output register empty.
// -----------------------------------------------------------------------------
// upload_chunk_planner_unit
// Splits an image upload into chunk commands no larger than the byte limit.
// -----------------------------------------------------------------------------
module upload_chunk_planner_unit (
	input  wire logic clk,
	input  wire logic arst_n,
	ucp_cfg_if.sink   cfg,
	ucp_req_if.sink   req,
	ucp_chunk_if.source chunk
);

	ucp_pkg::ctl_t   ctl;
	ucp_pkg::stat_t  st;
	ucp_pkg::req_t   req_data;
	ucp_pkg::chunk_t cmd_data;
	logic            out_valid;
	logic            req_ready;

	assign cfg.ready = 1'b1;
	assign req.ready = req_ready;

	always_comb begin
		req_data.image_width     = req.image_width;
		req_data.image_height    = req.image_height;
		req_data.layer_total     = req.layer_total;
		req_data.bytes_per_texel = req.bytes_per_texel;
	end

	ucp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req_ready),
		.st        (st),
		.ctl       (ctl)
	);

	ucp_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg.valid),
		.cfg_data  (cfg.max_chunk_bytes),
		.req       (req_data),
		.ctl       (ctl),
		.st        (st),
		.out_valid (out_valid),
		.cmd_data  (cmd_data),
		.out_ready (chunk.ready)
	);

	assign chunk.valid       = out_valid;
	assign chunk.first_layer = cmd_data.first_layer;
	assign chunk.layer_span  = cmd_data.layer_span;
	assign chunk.first_row   = cmd_data.first_row;
	assign chunk.row_span    = cmd_data.row_span;
	assign chunk.last        = cmd_data.last;
	assign chunk.status      = cmd_data.status;

endmodule
`default_nettype wire

### src/ucp_div.sv
`default_nettype none
// -----------------------------------------------------------------------------
// ucp_div
// Restoring unsigned divider, one quotient bit per cycle.
// -----------------------------------------------------------------------------
module ucp_div (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire ucp_pkg::div_t dividend,
	input  wire ucp_pkg::div_t divisor,
	output logic               busy,
	output logic               done,
	output ucp_pkg::div_t      quotient
);

	localparam int DW    = ucp_pkg::DIV_W;
	localparam int CNT_W = $clog2(DW);

	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DW-1:0]    rem_q;
	logic [DW-1:0]    quo_q;
	logic [DW-1:0]    dvs_q;

	logic [DW:0]   trial;
	logic [DW+1:0] diff;
	logic          ge;

	always_comb begin
		trial = {rem_q, quo_q[DW-1]};
		diff  = {1'b0, trial} - {2'b00, dvs_q};
		ge    = !diff[DW+1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == CNT_W'(DW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	// remainder stays below the divisor, so DW bits hold it
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DW-1:0] : trial[DW-1:0];
			quo_q <= {quo_q[DW-2:0], ge};
		end
	end

	assign busy     = busy_q;
	assign done     = done_q;
	assign quotient = quo_q;

endmodule
`default_nettype wire

### src/ucp_datapath.sv
`default_nettype none
// -----------------------------------------------------------------------------
// ucp_datapath
// Byte counts, divider, plan sizes, command counters and the output register.
// -----------------------------------------------------------------------------
module ucp_datapath (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            cfg_we,
	input  wire ucp_pkg::limit_t cfg_data,
	input  wire ucp_pkg::req_t   req,
	input  wire ucp_pkg::ctl_t   ctl,
	output ucp_pkg::stat_t       st,
	output logic                 out_valid,
	output ucp_pkg::chunk_t      cmd_data,
	input  wire logic            out_ready
);

	localparam int LW = ucp_pkg::LAYER_W;
	localparam int IW = ucp_pkg::IMG_W;
	localparam int DW = ucp_pkg::DIV_W;
	localparam int CW = ucp_pkg::CMDS_W;

	ucp_pkg::limit_t limit_q;
	ucp_pkg::img_t   width_q;
	ucp_pkg::img_t   height_q;
	ucp_pkg::layer_t layers_q;
	ucp_pkg::bpp_t   bpp_q;
	ucp_pkg::rowb_t  row_bytes_q;
	ucp_pkg::layb_t  layer_bytes_q;
	ucp_pkg::layer_t n_q;        // layers per command, saturated
	ucp_pkg::img_t   r_q;        // rows per band, saturated
	ucp_pkg::img_t   bands_q;
	ucp_pkg::cmds_t  ncmd_q;
	logic [LW:0]     l_q;
	ucp_pkg::img_t   y_q;
	logic            out_valid_q;
	ucp_pkg::chunk_t out_q;

	ucp_pkg::div_t dvd;
	ucp_pkg::div_t dvs;
	ucp_pkg::div_t quo;
	logic          div_busy;
	logic          div_done;

	logic [IW:0]   band_top;
	logic [LW:0]   rem_l;
	logic [LW:0]   span_l;
	logic          last_l;
	ucp_pkg::img_t rem_y;
	ucp_pkg::img_t rows_r;
	logic          band_last;
	logic          last_r;
	ucp_pkg::cmds_t layer_cap;
	ucp_pkg::chunk_t cmd_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= ucp_pkg::CHUNK_RESET;
		end else if (cfg_we) begin
			limit_q <= cfg_data;
		end
	end

	// divider operand select
	always_comb begin
		band_top = {1'b0, height_q} + {1'b0, r_q} - 1'b1;
		case (ctl.div_sel)
			ucp_pkg::DIV_LAYER: begin
				dvd = DW'(limit_q);
				dvs = DW'(layer_bytes_q);
			end
			ucp_pkg::DIV_ROW: begin
				dvd = DW'(limit_q);
				dvs = DW'(row_bytes_q);
			end
			ucp_pkg::DIV_BANDS: begin
				dvd = DW'(band_top);
				dvs = DW'(r_q);
			end
			default: begin
				dvd = DW'(limit_q);
				dvs = DW'(layer_bytes_q);
			end
		endcase
	end

	ucp_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (ctl.div_start),
		.dividend (dvd),
		.divisor  (dvs),
		.busy     (div_busy),
		.done     (div_done),
		.quotient (quo)
	);

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			width_q  <= req.image_width;
			height_q <= req.image_height;
			layers_q <= req.layer_total;
			bpp_q    <= req.bytes_per_texel;
		end
		if (ctl.mul_row) begin
			row_bytes_q <= ucp_pkg::rowb_t'(width_q) * ucp_pkg::rowb_t'(bpp_q);
		end
		if (ctl.mul_layer) begin
			layer_bytes_q <= ucp_pkg::layb_t'(height_q) * ucp_pkg::layb_t'(row_bytes_q);
		end
		if (ctl.set_n_all) begin
			n_q <= layers_q;
		end
		// quotients beyond the layer count or height act the same as the cap
		if (ctl.take_quo) begin
			case (ctl.div_sel)
				ucp_pkg::DIV_LAYER: n_q <= (|quo[DW-1:LW]) ? '1 : quo[LW-1:0];
				ucp_pkg::DIV_ROW:   r_q <= (|quo[DW-1:IW]) ? '1 : quo[IW-1:0];
				ucp_pkg::DIV_BANDS: bands_q <= quo[IW-1:0];
				default: ;
			endcase
		end
		if (ctl.mul_ncmd) begin
			ncmd_q <= ucp_pkg::cmds_t'(bands_q) * ucp_pkg::cmds_t'(layers_q);
		end
		if (ctl.emit_init) begin
			l_q <= '0;
			y_q <= '0;
		end else if (ctl.emit) begin
			if (!ctl.row_mode) begin
				l_q <= l_q + {1'b0, n_q};
			end else if (band_last) begin
				y_q <= '0;
				l_q <= l_q + 1'b1;
			end else begin
				y_q <= y_q + r_q;
			end
		end
	end

	// current command
	always_comb begin
		rem_l     = {1'b0, layers_q} - l_q;
		span_l    = (rem_l < {1'b0, n_q}) ? rem_l : {1'b0, n_q};
		last_l    = ({1'b0, l_q} + {2'b00, n_q}) >= {2'b00, layers_q};
		rem_y     = height_q - y_q;
		rows_r    = (rem_y < r_q) ? rem_y : r_q;
		band_last = ({1'b0, y_q} + {1'b0, r_q}) >= {1'b0, height_q};
		last_r    = band_last && ((l_q + 1'b1) == {1'b0, layers_q});
		layer_cap = CW'(ucp_pkg::MAX_COMMANDS) * CW'(n_q);

		cmd_next.first_layer = l_q[ucp_pkg::FLAYER_W-1:0];
		cmd_next.status      = ucp_pkg::ST_OK;
		if (ctl.row_mode) begin
			cmd_next.layer_span = LW'(1);
			cmd_next.first_row  = y_q[ucp_pkg::FROW_W-1:0];
			cmd_next.row_span   = rows_r;
			cmd_next.last       = last_r;
		end else begin
			cmd_next.layer_span = span_l[LW-1:0];
			cmd_next.first_row  = '0;
			cmd_next.row_span   = height_q;
			cmd_next.last       = last_l;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.emit || ctl.emit_err) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.emit_err) begin
			out_q             <= '0;
			out_q.last        <= 1'b1;
			out_q.status      <= ctl.err_code;
		end else if (ctl.emit) begin
			out_q <= cmd_next;
		end
	end

	always_comb begin
		st.bad_args   = (layers_q == '0) || (bpp_q == '0);
		st.fits       = layer_bytes_q <= ucp_pkg::layb_t'(limit_q);
		st.layer_zero = layer_bytes_q == '0;
		st.row_big    = ucp_pkg::layb_t'(row_bytes_q) > ucp_pkg::layb_t'(limit_q);
		st.div_done   = div_done;
		st.too_many   = ctl.row_mode ? (ncmd_q > CW'(ucp_pkg::MAX_COMMANDS))
		                             : (CW'(layers_q) > layer_cap);
		st.last_cmd   = ctl.row_mode ? last_r : last_l;
		st.out_free   = !out_valid_q || out_ready;
	end

	assign out_valid = out_valid_q;
	assign cmd_data  = out_q;

	a_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.div_start |-> !div_busy)
		else $error("divider started while busy");

	a_rows_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(div_done && ctl.take_quo && ctl.div_sel == ucp_pkg::DIV_ROW) |-> (quo != '0))
		else $error("zero rows per band");

	a_emit_range: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.emit |-> (l_q < {1'b0, layers_q}))
		else $error("command beyond last layer");

	a_err_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.status != ucp_pkg::ST_OK) |-> out_q.last)
		else $error("error result without last");

endmodule
`default_nettype wire

### src/ucp_ctrl.sv
`default_nettype none
// -----------------------------------------------------------------------------
// ucp_ctrl
// Sequencer for one request: sizes, divides, plan check, command issue.
// -----------------------------------------------------------------------------
module ucp_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           req_valid,
	output logic                req_ready,
	input  wire ucp_pkg::stat_t st,
	output ucp_pkg::ctl_t       ctl
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_MUL_ROW,
		S_MUL_LAYER,
		S_CHECK,
		S_DIV_LAYER,
		S_DIV_ROW,
		S_BANDS,
		S_DIV_BANDS,
		S_NCMD,
		S_COUNT,
		S_EMIT,
		S_ERR
	} state_t;

	state_t            state_q;
	logic              row_mode_q;
	ucp_pkg::status_t  err_q;

	always_comb begin
		ctl          = '0;
		ctl.row_mode = row_mode_q;
		ctl.err_code = err_q;
		ctl.div_sel  = ucp_pkg::DIV_LAYER;
		case (state_q)
			S_IDLE:      ctl.load = req_valid;
			S_MUL_ROW:   ctl.mul_row = 1'b1;
			S_MUL_LAYER: ctl.mul_layer = 1'b1;
			S_CHECK: begin
				if (!st.bad_args && st.fits) begin
					ctl.set_n_all = st.layer_zero;
					ctl.div_start = !st.layer_zero;
				end else if (!st.bad_args && !st.row_big) begin
					ctl.div_sel   = ucp_pkg::DIV_ROW;
					ctl.div_start = 1'b1;
				end
			end
			S_DIV_LAYER: ctl.take_quo = st.div_done;
			S_DIV_ROW: begin
				ctl.div_sel  = ucp_pkg::DIV_ROW;
				ctl.take_quo = st.div_done;
			end
			S_BANDS: begin
				ctl.div_sel   = ucp_pkg::DIV_BANDS;
				ctl.div_start = 1'b1;
			end
			S_DIV_BANDS: begin
				ctl.div_sel  = ucp_pkg::DIV_BANDS;
				ctl.take_quo = st.div_done;
			end
			S_NCMD:  ctl.mul_ncmd = 1'b1;
			S_COUNT: ctl.emit_init = !st.too_many;
			S_EMIT:  ctl.emit = st.out_free;
			S_ERR:   ctl.emit_err = st.out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			row_mode_q <= 1'b0;
			err_q      <= ucp_pkg::ST_OK;
		end else begin
			case (state_q)
				S_IDLE: if (req_valid) state_q <= S_MUL_ROW;
				S_MUL_ROW:   state_q <= S_MUL_LAYER;
				S_MUL_LAYER: state_q <= S_CHECK;
				S_CHECK: begin
					if (st.bad_args) begin
						err_q   <= ucp_pkg::ST_BAD_ARGS;
						state_q <= S_ERR;
					end else if (st.fits) begin
						row_mode_q <= 1'b0;
						state_q    <= st.layer_zero ? S_COUNT : S_DIV_LAYER;
					end else if (st.row_big) begin
						err_q   <= ucp_pkg::ST_ROW_BIG;
						state_q <= S_ERR;
					end else begin
						row_mode_q <= 1'b1;
						state_q    <= S_DIV_ROW;
					end
				end
				S_DIV_LAYER: if (st.div_done) state_q <= S_COUNT;
				S_DIV_ROW:   if (st.div_done) state_q <= S_BANDS;
				S_BANDS:     state_q <= S_DIV_BANDS;
				S_DIV_BANDS: if (st.div_done) state_q <= S_NCMD;
				S_NCMD:      state_q <= S_COUNT;
				S_COUNT: begin
					if (st.too_many) begin
						err_q   <= ucp_pkg::ST_TOO_MANY;
						state_q <= S_ERR;
					end else begin
						state_q <= S_EMIT;
					end
				end
				S_EMIT: if (st.out_free && st.last_cmd) state_q <= S_IDLE;
				S_ERR:  if (st.out_free) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign req_ready = (state_q == S_IDLE);

endmodule
`default_nettype wire
